[hw/rtl/segment_split_work_stealer_top_defines.svh]
// Assertion macros for the segment split work stealer checker.
`ifndef SEGMENT_SPLIT_WORK_STEALER_TOP_DEFINES_SVH
`define SEGMENT_SPLIT_WORK_STEALER_TOP_DEFINES_SVH

// Condition in the same cycle implies the consequence in the same cycle.
`define SSWS_ASSERT_NOW(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("ssws checker: same-cycle property failed");

// Condition implies the consequence in the next cycle.
`define SSWS_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("ssws checker: next-cycle property failed");

`endif

[hw/rtl/ssws_pkg.sv]
// Types and constants shared by the segment split work stealer.
`timescale 1ns / 1ps
package ssws_pkg;

    localparam int MAX_CH     = 16;
    localparam int CH_W       = 4;
    localparam int NCH_W      = 5;
    localparam int OFF_W      = 48;
    localparam int CNT_W      = 16;
    localparam int MC_W       = 25;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam int STEP_W     = $clog2(OFF_W);

    localparam logic [NCH_W-1:0] REQ_RESET       = NCH_W'(4);
    localparam logic [MC_W-1:0]  MIN_CHUNK_RESET = MC_W'(100 * 1024);

    typedef enum logic [MODE_W-1:0] {
        MODE_DIVIDE = 2'd0,
        MODE_RECV   = 2'd1,
        MODE_CLOSE  = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_SIZE = 2'd0,
        CFG_REQ_CH     = 2'd1,
        CFG_MIN_CHUNK  = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DIV1_GO,
        S_DIV1_RUN,
        S_DIV2_GO,
        S_DIV2_RUN,
        S_MOD,
        S_FILL,
        S_EVENT,
        S_CLOSE,
        S_SCAN_INIT,
        S_SCAN,
        S_STEAL_A,
        S_STEAL_B,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_DIV1_START,
        OP_SET_N,
        OP_DIV2_START,
        OP_SET_SEG,
        OP_MOD_STEP,
        OP_FILL,
        OP_EVENT,
        OP_CLOSE,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_STEAL_A,
        OP_STEAL_B,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  inactive;
        logic  div_busy;
        logic  mod_done;
        logic  fill_last;
        logic  scan_last;
        logic  emit_last;
        logic  ev_over;
        logic  exhausted;
        logic  found;
        logic  out_busy;
    } sts_t;

endpackage

[hw/rtl/ssws_if.sv]
// Handshake interfaces for the event, result and configuration channels.
`timescale 1ns / 1ps
interface ssws_evt_if
    import ssws_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [CH_W-1:0]   channel;
    logic [CNT_W-1:0]  byte_count;

    modport source (output valid, mode, channel, byte_count, input ready);
    modport sink (input valid, mode, channel, byte_count, output ready);
endinterface

interface ssws_res_if
    import ssws_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  out_channel;
    logic [OFF_W-1:0] range_start;
    logic [OFF_W-1:0] range_end;
    logic [OFF_W-1:0] write_offset;
    logic [CNT_W-1:0] write_length;
    logic             reassigned;
    logic [CH_W-1:0]  donor_channel;
    logic             channel_closed;
    logic             all_done;
    logic             last_result;

    modport source (output valid, out_channel, range_start, range_end, write_offset,
                    write_length, reassigned, donor_channel, channel_closed, all_done,
                    last_result, input ready);
    modport sink (input valid, out_channel, range_start, range_end, write_offset,
                  write_length, reassigned, donor_channel, channel_closed, all_done,
                  last_result, output ready);
endinterface

interface ssws_cfg_if
    import ssws_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/ssws_div.sv]
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
module ssws_div
    import ssws_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [OFF_W-1:0] dividend,
    input  logic [MC_W-1:0]  divisor,
    output logic             busy,
    output logic [OFF_W-1:0] quotient,
    output logic [MC_W-1:0]  remainder
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [OFF_W-1:0]  quo_reg, quo_next;
    logic [MC_W:0]     rem_reg, rem_next;
    logic [MC_W-1:0]   dvs_reg, dvs_next;
    logic [MC_W:0]     shifted;
    logic              fits;

    assign shifted = {rem_reg[MC_W-1:0], quo_reg[OFF_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[OFF_W-2:0], fits};
            rem_next = fits ? (shifted - {1'b0, dvs_reg}) : shifted;
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(OFF_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[MC_W-1:0];

endmodule

[hw/rtl/ssws_dp.sv]
// Datapath: range table, configuration, divider, scan and result register.
`timescale 1ns / 1ps
module ssws_dp
    import ssws_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    output sts_t sts,
    ssws_evt_if.sink   evt,
    ssws_res_if.source res,
    ssws_cfg_if.sink   cfg
);

    logic [OFF_W-1:0] next_mem [MAX_CH];
    logic [OFF_W-1:0] end_mem [MAX_CH];

    logic [OFF_W-1:0] total_reg;
    logic [NCH_W-1:0] req_reg;
    logic [MC_W-1:0]  mc_reg;
    logic [NCH_W-1:0] active_reg;
    logic [OFF_W-1:0] done_reg;

    mode_t            mode_reg;
    logic [CH_W-1:0]  ch_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NCH_W-1:0] n_reg;
    logic [OFF_W-1:0] seg_reg;
    logic [NCH_W-1:0] extra_reg;
    logic [OFF_W-1:0] pos_reg;
    logic [CH_W-1:0]  idx_reg;
    logic [OFF_W-1:0] best_reg;
    logic [CH_W-1:0]  donor_reg;
    logic             found_reg;
    logic [OFF_W-1:0] newpos_reg;
    logic [OFF_W-1:0] woff_reg;
    logic [CNT_W-1:0] len_reg;
    logic             closed_reg;
    logic             re_reg;
    logic             out_valid_reg;

    logic [CH_W-1:0]  rd_idx;
    logic [OFF_W-1:0] rd_next;
    logic [OFF_W-1:0] rd_end;
    logic [OFF_W-1:0] left;
    logic             over;
    logic [CNT_W-1:0] len;
    logic [MC_W-1:0]  mc;
    logic [OFF_W-1:0] newpos;
    logic             div_busy;
    logic             div_start;
    logic [MC_W-1:0]  div_divisor;
    logic [OFF_W-1:0] div_quo;
    logic [MC_W-1:0]  div_rem;
    logic [OFF_W-1:0] maxc;
    logic [NCH_W-1:0] nreq;
    logic [NCH_W-1:0] nsel;
    logic             emit_div;
    logic             in_n;
    logic             last_n;

    ssws_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (total_reg),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign mc          = (mc_reg == '0) ? MC_W'(1) : mc_reg;
    assign div_start   = (cmd.op == OP_DIV1_START) || (cmd.op == OP_DIV2_START);
    assign div_divisor = (cmd.op == OP_DIV1_START) ? mc : MC_W'(n_reg);
    assign emit_div    = (mode_reg == MODE_DIVIDE);

    always_comb
    begin
        unique case (cmd.op)
            OP_SCAN:    rd_idx = idx_reg;
            OP_STEAL_A: rd_idx = donor_reg;
            OP_EMIT:    rd_idx = emit_div ? idx_reg : ch_reg;
            default:    rd_idx = ch_reg;
        endcase
    end

    assign rd_next = next_mem[rd_idx];
    assign rd_end  = end_mem[rd_idx];
    assign left    = (rd_end > rd_next) ? (rd_end - rd_next) : '0;
    assign over    = {{(OFF_W-CNT_W){1'b0}}, cnt_reg} > left;
    assign len     = over ? left[CNT_W-1:0] : cnt_reg;
    assign newpos  = rd_next + (best_reg >> 1);

    assign maxc = (div_quo == '0) ? OFF_W'(1) : div_quo;
    assign nreq = (req_reg == '0) ? NCH_W'(1)
                : (req_reg > NCH_W'(MAX_CH)) ? NCH_W'(MAX_CH) : req_reg;
    assign nsel = (maxc < OFF_W'(nreq)) ? maxc[NCH_W-1:0] : nreq;

    assign in_n   = {1'b0, idx_reg} < n_reg;
    assign last_n = {1'b0, idx_reg} == (n_reg - NCH_W'(1));

    assign sts.mode      = mode_reg;
    assign sts.inactive  = {1'b0, ch_reg} >= active_reg;
    assign sts.div_busy  = div_busy;
    assign sts.mod_done  = (extra_reg == '0) || (OFF_W'(extra_reg) < seg_reg);
    assign sts.fill_last = idx_reg == CH_W'(MAX_CH - 1);
    assign sts.scan_last = {1'b0, idx_reg} == (active_reg - NCH_W'(1));
    assign sts.emit_last = last_n;
    assign sts.ev_over   = over;
    assign sts.exhausted = rd_next >= rd_end;
    assign sts.found     = found_reg;
    assign sts.out_busy  = out_valid_reg && !res.ready;

    assign cfg.ready = 1'b1;
    assign evt.ready = (cmd.op == OP_LATCH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg  <= '0;
            req_reg    <= REQ_RESET;
            mc_reg     <= MIN_CHUNK_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_TOTAL_SIZE: total_reg <= cfg.data[OFF_W-1:0];
                CFG_REQ_CH:     req_reg   <= cfg.data[NCH_W-1:0];
                CFG_MIN_CHUNK:  mc_reg    <= cfg.data[MC_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CH; i++)
            begin
                next_mem[i] <= '0;
                end_mem[i]  <= '0;
            end
            active_reg    <= NCH_W'(1);
            done_reg      <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_SET_SEG:
                begin
                    active_reg <= (div_quo == '0) ? NCH_W'(1) : n_reg;
                    done_reg   <= '0;
                    idx_reg    <= '0;
                end
                OP_FILL:
                begin
                    next_mem[idx_reg] <= in_n ? pos_reg : '0;
                    end_mem[idx_reg]  <= !in_n ? '0
                                       : last_n ? (pos_reg + seg_reg + OFF_W'(extra_reg))
                                       : (pos_reg + seg_reg);
                    idx_reg <= sts.fill_last ? '0 : (idx_reg + CH_W'(1));
                end
                OP_EVENT:
                begin
                    next_mem[ch_reg] <= rd_next + OFF_W'(len);
                    done_reg         <= done_reg + OFF_W'(len);
                end
                OP_SCAN_INIT:
                begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                end
                OP_SCAN:
                begin
                    if (left > best_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                    idx_reg <= sts.scan_last ? '0 : (idx_reg + CH_W'(1));
                end
                OP_STEAL_A:
                begin
                    if (found_reg)
                    begin
                        next_mem[ch_reg] <= newpos;
                        end_mem[ch_reg]  <= rd_end;
                    end
                end
                OP_STEAL_B:
                begin
                    end_mem[donor_reg] <= newpos_reg;
                end
                OP_EMIT:
                begin
                    if (emit_div)
                    begin
                        idx_reg <= idx_reg + CH_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LATCH:
            begin
                mode_reg   <= mode_t'(evt.mode);
                ch_reg     <= evt.channel;
                cnt_reg    <= evt.byte_count;
                woff_reg   <= '0;
                len_reg    <= '0;
                closed_reg <= 1'b0;
                re_reg     <= 1'b0;
                donor_reg  <= '0;
            end
            OP_SET_N:
            begin
                n_reg <= nsel;
            end
            OP_SET_SEG:
            begin
                pos_reg <= '0;
                if (div_quo == '0)
                begin
                    n_reg     <= NCH_W'(1);
                    seg_reg   <= total_reg;
                    extra_reg <= '0;
                end
                else
                begin
                    seg_reg   <= div_quo;
                    extra_reg <= div_rem[NCH_W-1:0];
                end
            end
            OP_MOD_STEP:
            begin
                extra_reg <= extra_reg - seg_reg[NCH_W-1:0];
            end
            OP_FILL:
            begin
                pos_reg <= pos_reg + seg_reg;
            end
            OP_EVENT:
            begin
                woff_reg   <= rd_next;
                len_reg    <= len;
                closed_reg <= over;
            end
            OP_CLOSE:
            begin
                closed_reg <= 1'b1;
            end
            OP_SCAN_INIT:
            begin
                best_reg <= OFF_W'(mc) - OFF_W'(1);
            end
            OP_SCAN:
            begin
                if (left > best_reg)
                begin
                    best_reg  <= left;
                    donor_reg <= idx_reg;
                end
            end
            OP_STEAL_A:
            begin
                newpos_reg <= newpos;
                re_reg     <= found_reg;
                if (!found_reg)
                begin
                    donor_reg <= '0;
                end
            end
            OP_EMIT:
            begin
                res.out_channel    <= rd_idx;
                res.range_start    <= rd_next;
                res.range_end      <= rd_end;
                res.write_offset   <= woff_reg;
                res.write_length   <= len_reg;
                res.reassigned     <= re_reg;
                res.donor_channel  <= re_reg ? donor_reg : '0;
                res.channel_closed <= closed_reg;
                res.all_done       <= done_reg == total_reg;
                res.last_result    <= emit_div ? last_n : 1'b1;
            end
            default: ;
        endcase
    end

    assign res.valid = out_valid_reg;

endmodule

[hw/rtl/ssws_ctrl.sv]
// Controller state machine that sequences the datapath for each event.
`timescale 1ns / 1ps
module ssws_ctrl
    import ssws_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic evt_valid,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (evt_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (sts.mode == MODE_UNUSED)
                    state_next = S_IDLE;
                else if (sts.mode == MODE_DIVIDE)
                    state_next = S_DIV1_GO;
                else if (sts.inactive)
                    state_next = S_EMIT;
                else if (sts.mode == MODE_RECV)
                    state_next = S_EVENT;
                else
                    state_next = S_CLOSE;
            end
            S_DIV1_GO:  state_next = S_DIV1_RUN;
            S_DIV1_RUN:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_DIV2_GO;
                end
            end
            S_DIV2_GO:  state_next = S_DIV2_RUN;
            S_DIV2_RUN:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (sts.mod_done)
                begin
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                if (sts.fill_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EVENT:     state_next = sts.ev_over ? S_SCAN_INIT : S_EMIT;
            S_CLOSE:     state_next = sts.exhausted ? S_SCAN_INIT : S_EMIT;
            S_SCAN_INIT: state_next = S_SCAN;
            S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_STEAL_A;
                end
            end
            S_STEAL_A:   state_next = sts.found ? S_STEAL_B : S_EMIT;
            S_STEAL_B:   state_next = S_EMIT;
            S_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    if (sts.mode != MODE_DIVIDE || sts.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op = OP_NONE;
        unique case (state_reg)
            S_IDLE:      cmd.op = evt_valid ? OP_LATCH : OP_NONE;
            S_DIV1_GO:   cmd.op = OP_DIV1_START;
            S_DIV1_RUN:  cmd.op = sts.div_busy ? OP_NONE : OP_SET_N;
            S_DIV2_GO:   cmd.op = OP_DIV2_START;
            S_DIV2_RUN:  cmd.op = sts.div_busy ? OP_NONE : OP_SET_SEG;
            S_MOD:       cmd.op = sts.mod_done ? OP_NONE : OP_MOD_STEP;
            S_FILL:      cmd.op = OP_FILL;
            S_EVENT:     cmd.op = OP_EVENT;
            S_CLOSE:     cmd.op = OP_CLOSE;
            S_SCAN_INIT: cmd.op = OP_SCAN_INIT;
            S_SCAN:      cmd.op = OP_SCAN;
            S_STEAL_A:   cmd.op = OP_STEAL_A;
            S_STEAL_B:   cmd.op = OP_STEAL_B;
            S_EMIT:      cmd.op = sts.out_busy ? OP_NONE : OP_EMIT;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

[hw/rtl/segment_split_work_stealer_top.sv]
// Top level of the segment split work stealer.
//
//  Port   Direction  Word carried
//  evt    sink       mode, channel, byte_count
//  res    source     one range report per word, last_result on the final one
//  cfg    sink       register index and write data, always ready
//
// A receive or close event passes dispatch and its event or close state before the emit
// state, an inactive channel goes from dispatch straight to emit; an overrun or exhausted
// channel adds a scan over the active channels and a steal step, and a second if it steals.
// A divide runs the serial divider twice, reduces the remainder, writes all 16 table
// entries one per cycle, then emits one word per channel, one per cycle while res is ready.
// Reset clears the table and done count, sets one active channel and reloads the config.
// A stalled result holds its word; the next word waits in the controller.
`timescale 1ns / 1ps
module segment_split_work_stealer_top
    import ssws_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    ssws_evt_if.sink   evt,
    ssws_res_if.source res,
    ssws_cfg_if.sink   cfg
);

    cmd_t cmd;
    sts_t sts;

    ssws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    ssws_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .sts   (sts),
        .evt   (evt),
        .res   (res),
        .cfg   (cfg)
    );

endmodule

[hw/rtl/ssws_checker.sv]
// Port-level checker for the segment split work stealer and its bind.
`timescale 1ns / 1ps
`include "segment_split_work_stealer_top_defines.svh"
module ssws_checker
    import ssws_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             evt_valid,
    input logic             evt_ready,
    input logic             res_valid,
    input logic             res_ready,
    input logic [OFF_W-1:0] res_range_start,
    input logic [CNT_W-1:0] res_write_length,
    input logic             res_reassigned,
    input logic             res_closed,
    input logic             res_last
);

    `SSWS_ASSERT_NEXT(a_stall_holds, res_valid && !res_ready, res_valid && $stable(res_range_start))
    `SSWS_ASSERT_NEXT(a_busy_after_accept, evt_valid && evt_ready, !evt_ready)
    `SSWS_ASSERT_NOW(a_steal_needs_close, res_valid && res_reassigned, res_closed)
    `SSWS_ASSERT_NOW(a_write_single, res_valid && (res_write_length != '0 || res_closed), res_last)

endmodule

bind segment_split_work_stealer_top ssws_checker u_ssws_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .evt_valid        (evt.valid),
    .evt_ready        (evt.ready),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_range_start  (res.range_start),
    .res_write_length (res.write_length),
    .res_reassigned   (res.reassigned),
    .res_closed       (res.channel_closed),
    .res_last         (res.last_result)
);

[tb/tb_segment_split_work_stealer_top.sv]
// Self-checking testbench for the segment split work stealer.
`timescale 1ns / 1ps
module tb_segment_split_work_stealer_top;
    import ssws_pkg::*;

    typedef struct packed {
        mode_t            mode;
        logic [CH_W-1:0]  channel;
        logic [CNT_W-1:0] byte_count;
    } event_word_t;

    typedef struct packed {
        logic [CH_W-1:0]  out_channel;
        logic [OFF_W-1:0] range_start;
        logic [OFF_W-1:0] range_end;
        logic [OFF_W-1:0] write_offset;
        logic [CNT_W-1:0] write_length;
        logic             reassigned;
        logic [CH_W-1:0]  donor_channel;
        logic             channel_closed;
        logic             all_done;
        logic             last_result;
    } range_report_t;

    logic clk;
    logic rst_n;

    ssws_evt_if evt ();
    ssws_res_if res ();
    ssws_cfg_if cfg ();

    segment_split_work_stealer_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt.sink),
        .res   (res.source),
        .cfg   (cfg.sink)
    );

    // Shadow copy of the scheduler state.
    logic [OFF_W-1:0] sh_next [MAX_CH];
    logic [OFF_W-1:0] sh_end [MAX_CH];
    int unsigned      sh_active;
    logic [OFF_W-1:0] sh_done;
    logic [OFF_W-1:0] sh_total;
    logic [NCH_W-1:0] sh_req;
    logic [MC_W-1:0]  sh_min_chunk;

    event_word_t   pending_events [$];
    range_report_t expected_reports [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  mismatches;
    int  reports_seen;
    int  events_sent;
    int  steals_seen;
    longint cycle_count;
    logic evt_accept;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [OFF_W-1:0] left_in(int c);
        return (sh_end[c] > sh_next[c]) ? sh_end[c] - sh_next[c] : '0;
    endfunction

    function automatic range_report_t make_report(int c, logic [OFF_W-1:0] woff,
                                                  logic [CNT_W-1:0] wlen, logic re,
                                                  logic [CH_W-1:0] donor, logic closed,
                                                  logic last);
        range_report_t r;
        r.out_channel    = CH_W'(c);
        r.range_start    = sh_next[c];
        r.range_end      = sh_end[c];
        r.write_offset   = woff;
        r.write_length   = wlen;
        r.reassigned     = re;
        r.donor_channel  = re ? donor : '0;
        r.channel_closed = closed;
        r.all_done       = (sh_done == sh_total);
        r.last_result    = last;
        return r;
    endfunction

    function automatic logic try_steal(int c, output logic [CH_W-1:0] donor);
        logic [OFF_W-1:0] best;
        logic [OFF_W-1:0] r;
        logic             found;
        found = 1'b0;
        donor = '0;
        if (sh_next[c] < sh_end[c])
            return 1'b0;
        best = OFF_W'(((sh_min_chunk == 0) ? 1 : sh_min_chunk) - 1);
        for (int j = 0; j < sh_active; j++)
        begin
            r = left_in(j);
            if (r > best)
            begin
                best  = r;
                donor = CH_W'(j);
                found = 1'b1;
            end
        end
        if (!found)
            return 1'b0;
        sh_end[c]     = sh_end[donor];
        sh_end[donor] = sh_next[donor] + (best >> 1);
        sh_next[c]    = sh_end[donor];
        return 1'b1;
    endfunction

    function automatic void predict_ranges(event_word_t ev);
        logic [OFF_W-1:0] mc;
        logic [OFF_W-1:0] maxc;
        logic [OFF_W-1:0] n;
        logic [OFF_W-1:0] seg;
        logic [OFF_W-1:0] rem;
        logic [OFF_W-1:0] woff;
        logic [CNT_W-1:0] len;
        logic [CH_W-1:0]  donor;
        logic             closed;
        logic             re;
        int               c;
        c = ev.channel;
        if (ev.mode == MODE_DIVIDE)
        begin
            mc   = (sh_min_chunk == 0) ? 1 : OFF_W'(sh_min_chunk);
            maxc = sh_total / mc;
            if (maxc < 1)
                maxc = 1;
            n = sh_req;
            if (n < 1)
                n = 1;
            if (n > MAX_CH)
                n = MAX_CH;
            if (maxc < n)
                n = maxc;
            seg = sh_total / n;
            if (seg == 0)
            begin
                n   = 1;
                seg = sh_total;
            end
            for (int i = 0; i < MAX_CH; i++)
            begin
                sh_next[i] = (i < n) ? seg * i : '0;
                sh_end[i]  = (i < n) ? seg * i + seg : '0;
            end
            if (seg != 0)
                sh_end[n-1] = sh_end[n-1] + sh_total % seg;
            sh_active = 32'(n);
            sh_done   = '0;
            for (int i = 0; i < n; i++)
                expected_reports.push_back(make_report(i, '0, '0, 0, '0, 0, i + 1 == n));
            return;
        end
        if (ev.mode == MODE_UNUSED)
            return;
        if (c >= sh_active)
        begin
            expected_reports.push_back(make_report(c, '0, '0, 0, '0, 0, 1));
            return;
        end
        re = 1'b0;
        donor = '0;
        if (ev.mode == MODE_RECV)
        begin
            rem    = left_in(c);
            woff   = sh_next[c];
            closed = ev.byte_count > rem;
            len    = closed ? CNT_W'(rem) : ev.byte_count;
            sh_next[c] = sh_next[c] + len;
            sh_done    = sh_done + len;
            if (closed)
                re = try_steal(c, donor);
            expected_reports.push_back(make_report(c, woff, len, re, donor, closed, 1));
        end
        else
        begin
            re = try_steal(c, donor);
            expected_reports.push_back(make_report(c, '0, '0, re, donor, 1, 1));
        end
    endfunction

    // Event driver; also drives random result stalls.
    always @(negedge clk)
    begin
        if (rst_n && (!evt.valid || evt_accept))
        begin
            if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                event_word_t ev;
                ev = pending_events.pop_front();
                evt.valid      <= 1'b1;
                evt.mode       <= ev.mode;
                evt.channel    <= ev.channel;
                evt.byte_count <= ev.byte_count;
            end
            else
                evt.valid <= 1'b0;
        end
        res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on event acceptance, check result words.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        evt_accept  <= rst_n && evt.valid && evt.ready;
        if (rst_n && evt.valid && evt.ready)
        begin
            event_word_t ev;
            ev.mode       = mode_t'(evt.mode);
            ev.channel    = evt.channel;
            ev.byte_count = evt.byte_count;
            predict_ranges(ev);
            events_sent <= events_sent + 1;
        end
        if (rst_n && res.valid && res.ready)
        begin
            range_report_t got;
            range_report_t exp_r;
            got = '{res.out_channel, res.range_start, res.range_end, res.write_offset,
                    res.write_length, res.reassigned, res.donor_channel,
                    res.channel_closed, res.all_done, res.last_result};
            reports_seen <= reports_seen + 1;
            if (got.reassigned)
                steals_seen <= steals_seen + 1;
            if (expected_reports.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result word: %p", got);
            end
            else
            begin
                exp_r = expected_reports.pop_front();
                if (got !== exp_r)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                    begin
                        $display("mismatch at cycle %0d", cycle_count);
                        $display("  expected %p", exp_r);
                        $display("  actual   %p", got);
                    end
                end
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            CFG_TOTAL_SIZE: sh_total = value;
            CFG_REQ_CH:     sh_req = value[NCH_W-1:0];
            default:        sh_min_chunk = value[MC_W-1:0];
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_events.size() > 0 || evt.valid || expected_reports.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic queue_event(mode_t m, int ch, int cnt);
        event_word_t ev;
        ev.mode       = m;
        ev.channel    = CH_W'(ch);
        ev.byte_count = CNT_W'(cnt);
        pending_events.push_back(ev);
    endtask

    // Divide, then mostly receives that consume ranges, some closes and noise.
    task automatic random_phase(int items);
        int r;
        queue_event(MODE_DIVIDE, $urandom_range(15), $urandom_range(65535));
        for (int i = 0; i < items; i++)
        begin
            r = $urandom_range(99);
            if (r < 60)
                queue_event(MODE_RECV, $urandom_range(sh_req > 1 ? sh_req - 1 : 0),
                            $urandom_range(99) < 70 ? $urandom_range(4000) : $urandom);
            else if (r < 75)
                queue_event(MODE_CLOSE, $urandom_range(15), $urandom);
            else if (r < 85)
                queue_event(MODE_RECV, $urandom_range(15), $urandom);
            else if (r < 92)
                queue_event(MODE_DIVIDE, $urandom_range(15), $urandom);
            else
                queue_event(MODE_UNUSED, $urandom_range(15), $urandom);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        evt.valid = 1'b0;
        evt.mode = '0;
        evt.channel = '0;
        evt.byte_count = '0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        reports_seen = 0;
        events_sent = 0;
        steals_seen = 0;
        cycle_count = 0;
        evt_accept = 1'b0;
        for (int i = 0; i < MAX_CH; i++)
        begin
            sh_next[i] = '0;
            sh_end[i] = '0;
        end
        sh_active = 1;
        sh_done = '0;
        sh_total = '0;
        sh_req = REQ_RESET;
        sh_min_chunk = MIN_CHUNK_RESET;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset state, inactive channels, unused mode.
        queue_event(MODE_RECV, 0, 5);
        queue_event(MODE_CLOSE, 15, 0);
        queue_event(MODE_UNUSED, 3, 3);
        queue_event(MODE_DIVIDE, 0, 0);
        drain();

        // Small transfer: exact fill, overrun with steal, close with bytes left.
        write_reg(CFG_TOTAL_SIZE, 48'd40000);
        write_reg(CFG_REQ_CH, 5'd4);
        write_reg(CFG_MIN_CHUNK, 25'd1000);
        queue_event(MODE_DIVIDE, 9, 1);
        queue_event(MODE_RECV, 0, 10000);
        queue_event(MODE_RECV, 1, 65535);
        queue_event(MODE_CLOSE, 2, 0);
        queue_event(MODE_CLOSE, 0, 0);
        queue_event(MODE_RECV, 7, 100);
        queue_event(MODE_RECV, 3, 0);
        drain();

        // Requested count of zero and above the channel limit, tiny and maximum sizes.
        write_reg(CFG_REQ_CH, 5'd0);
        write_reg(CFG_TOTAL_SIZE, 48'd3);
        write_reg(CFG_MIN_CHUNK, 25'd0);
        queue_event(MODE_DIVIDE, 0, 0);
        queue_event(MODE_RECV, 0, 3);
        drain();
        write_reg(CFG_REQ_CH, 5'd31);
        queue_event(MODE_DIVIDE, 0, 0);
        queue_event(MODE_RECV, 1, 1);
        queue_event(MODE_CLOSE, 0, 0);
        drain();
        write_reg(CFG_TOTAL_SIZE, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_MIN_CHUNK, 25'h1FF_FFFF);
        queue_event(MODE_DIVIDE, 0, 0);
        queue_event(MODE_RECV, 15, 65535);
        drain();

        // Random phases across settings and idling profiles.
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = (p == 1 || p == 3) ? 87 : 0;
            recv_stall_pct = (p == 2 || p == 3) ? 87 : 0;
            if (p == 3)
            begin
                send_idle_pct  = 10;
                recv_stall_pct = 10;
            end
            write_reg(CFG_TOTAL_SIZE, (p == 0) ? 48'd16 : 48'($urandom_range(20000, 200000)));
            write_reg(CFG_REQ_CH, (p == 0) ? 5'd16 : 5'($urandom_range(16, 1)));
            write_reg(CFG_MIN_CHUNK, (p == 0) ? 25'd1 : 25'($urandom_range(8000, 1)));
            random_phase(65);
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        $display("covered %0d events and %0d result words, %0d with a steal",
                 events_sent, reports_seen, steals_seen);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin
        if (cycle_count > 400000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end
endmodule
